// ===== rtl/wmd_pkg.sv =====
// Shared package for the weather message deframer.
// Holds signature tables, status codes and the result descriptor passed from core to emitter.
// No dependencies.
package wmd_pkg;

  localparam int unsigned BUFR_SIG_LEN   = 4;
  localparam int unsigned CREX_SIG_LEN   = 6;
  localparam int unsigned BUFR_HDR_BYTES = 8;
  localparam int unsigned BUFR_MIN_LEN   = 12;
  localparam int unsigned END_MARK_LEN   = 8;

  typedef logic [2:0] status_t;
  localparam status_t ST_NONE       = 3'd0;
  localparam status_t ST_COMPLETE   = 3'd1;
  localparam status_t ST_SHORT_LEN  = 3'd2;
  localparam status_t ST_INCOMPLETE = 3'd3;
  localparam status_t ST_NO_MSG     = 3'd4;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_SINGLE,
    EV_BURST
  } ev_kind_t;

  // One descriptor per processed item: nothing, one result, or a signature replay.
  typedef struct packed {
    ev_kind_t    kind;
    logic        crex;
    logic [7:0]  data;
    logic        bvalid;
    status_t     status;
  } event_t;

  function automatic logic [3:0] sig_len(input logic crex);
    logic [3:0] len;
    len = crex ? 4'(CREX_SIG_LEN) : 4'(BUFR_SIG_LEN);
    return len;
  endfunction

  function automatic logic [7:0] sig_char(input logic crex, input logic [2:0] idx);
    logic [7:0] ch;
    case ({crex, idx})
      4'b0_000: ch = 8'h42;  // B
      4'b0_001: ch = 8'h55;  // U
      4'b0_010: ch = 8'h46;  // F
      4'b0_011: ch = 8'h52;  // R
      4'b1_000: ch = 8'h43;  // C
      4'b1_001: ch = 8'h52;  // R
      4'b1_010: ch = 8'h45;  // E
      4'b1_011: ch = 8'h58;  // X
      4'b1_100: ch = 8'h2B;  // +
      4'b1_101: ch = 8'h2B;  // +
      default:  ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] end_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h2B;
      3'd1:    ch = 8'h2B;
      3'd2:    ch = 8'h0D;
      3'd3:    ch = 8'h0A;
      default: ch = 8'h37;
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/wmd_core.sv =====
// Framing core: holds hunt/header/body state and turns one registered item into a descriptor.
// Depends on wmd_pkg.
module wmd_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic            cfg_wdata,
  input  logic            item_action,
  input  logic [7:0]      item_byte,
  input  logic            advance,
  output wmd_pkg::event_t ev
);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_BHDR,
    PH_BBODY,
    PH_CBODY
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic        mode_r;
  logic [3:0]  match_r, match_nxt;
  logic [23:0] dlen_r, dlen_nxt;
  logic [23:0] seen_r, seen_nxt;

  always_comb begin
    logic [3:0]  len;
    logic [3:0]  mp;
    logic [3:0]  pos;
    logic [23:0] seen_inc;
    logic        crlf;

    phase_nxt = phase_r;
    match_nxt = match_r;
    dlen_nxt  = dlen_r;
    seen_nxt  = seen_r;
    ev.kind   = wmd_pkg::EV_NONE;
    ev.crex   = mode_r;
    ev.data   = item_byte;
    ev.bvalid = 1'b1;
    ev.status = wmd_pkg::ST_NONE;
    len       = wmd_pkg::sig_len(mode_r);
    mp        = 4'd0;
    pos       = 4'd0;
    seen_inc  = seen_r + 24'd1;
    crlf      = (item_byte == 8'h0D) || (item_byte == 8'h0A);

    if (item_action) begin
      ev.kind   = wmd_pkg::EV_SINGLE;
      ev.data   = 8'h00;
      ev.bvalid = 1'b0;
      ev.status = (phase_r == PH_HUNT) ? wmd_pkg::ST_NO_MSG : wmd_pkg::ST_INCOMPLETE;
      phase_nxt = PH_HUNT;
      match_nxt = 4'd0;
      dlen_nxt  = 24'd0;
      seen_nxt  = 24'd0;
    end else begin
      case (phase_r)
        PH_HUNT: begin
          mp = (match_r >= len) ? 4'd0 : match_r;
          // a mismatch retests the byte as a fresh first character
          if (item_byte == wmd_pkg::sig_char(mode_r, mp[2:0])) begin
            mp = mp + 4'd1;
          end else begin
            mp = (item_byte == wmd_pkg::sig_char(mode_r, 3'd0)) ? 4'd1 : 4'd0;
          end
          if (mp >= len) begin
            ev.kind   = wmd_pkg::EV_BURST;
            match_nxt = 4'd0;
            dlen_nxt  = 24'd0;
            if (mode_r) begin
              phase_nxt = PH_CBODY;
              seen_nxt  = 24'd0;
            end else begin
              phase_nxt = PH_BHDR;
              seen_nxt  = 24'(wmd_pkg::BUFR_SIG_LEN);
            end
          end else begin
            match_nxt = mp;
          end
        end
        PH_BHDR: begin
          ev.kind  = wmd_pkg::EV_SINGLE;
          seen_nxt = seen_inc;
          if (seen_inc < 24'(wmd_pkg::BUFR_HDR_BYTES)) begin
            dlen_nxt = {dlen_r[15:0], item_byte};
          end else if (dlen_r < 24'(wmd_pkg::BUFR_MIN_LEN)) begin
            ev.status = wmd_pkg::ST_SHORT_LEN;
            phase_nxt = PH_HUNT;
            match_nxt = 4'd0;
            dlen_nxt  = 24'd0;
            seen_nxt  = 24'd0;
          end else begin
            phase_nxt = PH_BBODY;
          end
        end
        PH_BBODY: begin
          ev.kind  = wmd_pkg::EV_SINGLE;
          seen_nxt = seen_inc;
          if (seen_inc >= dlen_r) begin
            ev.status = wmd_pkg::ST_COMPLETE;
            phase_nxt = PH_HUNT;
            match_nxt = 4'd0;
            dlen_nxt  = 24'd0;
            seen_nxt  = 24'd0;
          end
        end
        PH_CBODY: begin
          ev.kind = wmd_pkg::EV_SINGLE;
          pos     = (match_r > 4'd7) ? 4'd0 : match_r;
          if (pos == 4'd2 && crlf) begin
            pos = 4'd3;
          end else if (pos == 4'd3 && crlf) begin
            pos = 4'd3;
          end else if (pos == 4'd3 && item_byte == 8'h37) begin
            pos = 4'd5;
          end else if (item_byte == wmd_pkg::end_char(pos[2:0])) begin
            pos = pos + 4'd1;
          end else begin
            pos = (item_byte == 8'h2B) ? 4'd1 : 4'd0;
          end
          if (pos >= 4'(wmd_pkg::END_MARK_LEN)) begin
            ev.status = wmd_pkg::ST_COMPLETE;
            phase_nxt = PH_HUNT;
            match_nxt = 4'd0;
            dlen_nxt  = 24'd0;
            seen_nxt  = 24'd0;
          end else begin
            match_nxt = pos;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      mode_r  <= 1'b0;
      match_r <= 4'd0;
      dlen_r  <= 24'd0;
      seen_r  <= 24'd0;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
      if (phase_r == PH_HUNT) begin
        match_r <= 4'd0;
      end
    end else if (advance) begin
      phase_r <= phase_nxt;
      match_r <= match_nxt;
      dlen_r  <= dlen_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

// ===== rtl/wmd_emit.sv =====
// Result emitter: output register, one result a cycle unless stalled; replays signatures.
// Depends on wmd_pkg.
module wmd_emit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  wmd_pkg::event_t ev,
  output logic            ready,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [15:0]     out_tdata,
  output logic            out_tlast
);

  logic            busy_r;
  logic            burst_r;
  logic            crex_r;
  logic [2:0]      idx_r;
  logic [7:0]      byte_r;
  logic            bvalid_r;
  wmd_pkg::status_t status_r;
  logic [7:0]      data_c;
  logic            last_c;
  logic [3:0]      len_c;

  assign len_c  = wmd_pkg::sig_len(crex_r);
  assign last_c = burst_r ? ({1'b0, idx_r} == (len_c - 4'd1)) : 1'b1;
  assign data_c = burst_r ? wmd_pkg::sig_char(crex_r, idx_r) : byte_r;

  assign ready      = !busy_r || (out_tready && last_c);
  assign out_tvalid = busy_r;
  assign out_tlast  = last_c;
  assign out_tdata  = {4'b0000, status_r, bvalid_r, data_c};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 3'd0;
    end else if (load) begin
      busy_r <= 1'b1;
      idx_r  <= 3'd0;
    end else if (busy_r && out_tready) begin
      if (last_c) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    if (load) begin
      burst_r  <= (ev.kind == wmd_pkg::EV_BURST);
      crex_r   <= ev.crex;
      byte_r   <= ev.data;
      bvalid_r <= (ev.kind == wmd_pkg::EV_BURST) ? 1'b1 : ev.bvalid;
      status_r <= (ev.kind == wmd_pkg::EV_BURST) ? wmd_pkg::ST_NONE : ev.status;
    end
  end

endmodule

// ===== rtl/weather_message_deframer.sv =====
// Top level of the weather message deframer (BUFR / CREX framing).
// Instantiates wmd_core and wmd_emit; uses wmd_pkg.
//
// Takes a byte stream one item per clock while in_tready is high and delivers one message
// at a time on the out_ stream. Bytes ahead of a start signature are dropped; when the
// signature completes its bytes are replayed as 4 (BUFR) or 6 (CREX) results, one per
// cycle while out_tready is high, and the input stalls once the input register is full.
// Every other item yields at most one result; the item is held in the input register and
// its result in the result register. The replay counter in the emitter sets the rate during
// signatures. format_mode (cfg_wdata) selects BUFR length framing (0) or
// CREX text framing (1); write it only while the block is idle. End of stream
// (in_tuser = 1) yields one result with byte_valid low and status 4 (no message) or
// 3 (incomplete), and returns the framer to hunting.
module weather_message_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,     // format_mode
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [7:0] data_byte
  input  logic        in_tuser,      // [0] action: 1 = end of stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,     // [7:0] out_byte, [8] byte_valid, [11:9] status, [15:12] 0
  output logic        out_tlast      // last result caused by the item
);

  logic            s1_valid_r;
  logic            s1_action_r;
  logic [7:0]      s1_byte_r;
  logic            s1_take;
  logic            emit_ready;
  logic            emit_load;
  wmd_pkg::event_t ev;

  // Advance the framer when the item needs no result or the emitter can take it.
  assign s1_take   = s1_valid_r && ((ev.kind == wmd_pkg::EV_NONE) || emit_ready);
  assign emit_load = s1_valid_r && (ev.kind != wmd_pkg::EV_NONE) && emit_ready;
  assign in_tready = !s1_valid_r || s1_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_take) begin
      s1_valid_r <= 1'b0;
    end
  end

  // hold the item payload until the framer consumes it
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_action_r <= in_tuser;
      s1_byte_r   <= in_tdata;
    end
  end

  wmd_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .item_action (s1_action_r),
    .item_byte   (s1_byte_r),
    .advance     (s1_take),
    .ev          (ev)
  );

  wmd_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (emit_load),
    .ev         (ev),
    .ready      (emit_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/wmd_checker.sv =====
// Port-level checker for the weather message deframer, bound to the top level.
// Depends on wmd_pkg and weather_message_deframer.
module wmd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // any status closes the item's results
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[11:9] != wmd_pkg::ST_NONE) |-> out_tlast)
    else $error("status result not marked last");

  // a result outside a message is an end-of-stream report
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[8] |->
      (out_tdata[11:9] == wmd_pkg::ST_INCOMPLETE) || (out_tdata[11:9] == wmd_pkg::ST_NO_MSG))
    else $error("invalid byte without end-of-stream status");

  // end-of-stream results carry a zero byte and pad bits stay zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[8] |-> (out_tdata[7:0] == 8'h00) && (out_tdata[15:12] == 4'h0))
    else $error("end-of-stream result carries data");

endmodule

bind weather_message_deframer wmd_checker u_wmd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
